/* design/aptp_pkg.sv */
// ----------------------------------------------------------------------------
// Adaptive transmit power package
// Shared constants, codes, types and helper functions for the link table.
// ----------------------------------------------------------------------------
package aptp_pkg;

    localparam int ENTRIES   = 8;
    localparam int ADDR_BITS = 16;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // Transaction opcodes.
    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_POWER  = 3'd0,
        CFG_POWER_STEP = 3'd1,
        CFG_FAIL_LIMIT = 3'd2,
        CFG_MIN_MSGS   = 3'd3,
        CFG_RATIO      = 3'd4,
        CFG_INTERVAL   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [7:0] max_power;
        logic [6:0]        power_step;
        logic [7:0]        fail_limit;
        logic [9:0]        min_messages;
        logic [8:0]        ratio_target;
        logic [15:0]       interval_ticks;
    } cfg_t;

    // Token that walks along the cell chain.
    typedef struct packed {
        logic                 valid;
        op_t                  op;
        logic [ADDR_BITS-1:0] addr;
        logic                 delivered;
        logic                 hop;
        logic                 hit;
        logic signed [7:0]    power;
        logic                 free_found;
        logic [IDX_W-1:0]     free_idx;
    } tok_t;

    // New-link write broadcast to all cells.
    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     idx;
        logic [ADDR_BITS-1:0] addr;
        logic signed [7:0]    power;
    } alloc_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    // Stable power plus one step, limited to max_power and the field range.
    function automatic logic signed [7:0] raise_power(input logic signed [7:0] p,
                                                      input logic [6:0] step,
                                                      input logic signed [7:0] maxp);
        logic signed [9:0] s;
        s = 10'(p) + $signed({3'b000, step});
        if (s > 10'(maxp))
            s = 10'(maxp);
        if (s > 10'sd127)
            s = 10'sd127;
        if (s < -10'sd128)
            s = -10'sd128;
        raise_power = s[7:0];
    endfunction

    // Power minus one step, clamped to the field range.
    function automatic logic signed [7:0] lower_power(input logic signed [7:0] p,
                                                      input logic [6:0] step);
        logic signed [9:0] s;
        s = 10'(p) - $signed({3'b000, step});
        if (s < -10'sd128)
            s = -10'sd128;
        lower_power = s[7:0];
    endfunction

endpackage

/* design/aptp_if.sv */
// ----------------------------------------------------------------------------
// Adaptive transmit power channels
// Valid/ready channels for event transactions and power results.
// ----------------------------------------------------------------------------
interface aptp_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     opcode;
    logic [aptp_pkg::ADDR_BITS-1:0] dest_addr;
    logic                           delivered;
    logic                           is_next_hop;

    modport source (output valid, opcode, dest_addr, delivered, is_next_hop, input ready);
    modport sink   (input valid, opcode, dest_addr, delivered, is_next_hop, output ready);
endinterface

interface aptp_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] tx_power;
    logic              power_valid;
    logic              table_full;

    modport source (output valid, tx_power, power_valid, table_full, input ready);
    modport sink   (input valid, tx_power, power_valid, table_full, output ready);
endinterface

/* design/aptp_cell.sv */
// ----------------------------------------------------------------------------
// Link cell
// Holds one neighbor link and acts on the token as it passes by.
// ----------------------------------------------------------------------------
module aptp_cell
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  aptp_pkg::cfg_t             cfg,
    input  logic [aptp_pkg::IDX_W-1:0] cell_idx,
    input  aptp_pkg::alloc_t           alloc,
    input  aptp_pkg::tok_t             tok_in,
    output aptp_pkg::tok_t             tok_out
);
    import aptp_pkg::*;

    logic                 used_reg, used_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic signed [7:0]    stable_reg, stable_next;
    logic signed [7:0]    trial_p_reg, trial_p_next;
    logic [CNT_W-1:0]     sent_reg, sent_next;
    logic [CNT_W-1:0]     deliv_reg, deliv_next;
    logic [CNT_W-1:0]     fail_reg, fail_next;
    logic                 trial_reg, trial_next;
    logic [CNT_W-1:0]     timer_reg, timer_next;

    logic             match;
    logic [CNT_W-1:0] sent_inc, deliv_inc, fail_inc, timer_dec;
    logic [24:0]      lhs, rhs;
    logic             over, bad, good;

    assign match = used_reg && (addr_reg == tok_in.addr);

    // Report arithmetic: updated counters and the cross-multiplied ratio test.
    always_comb
    begin
        sent_inc  = sat_inc(sent_reg);
        deliv_inc = tok_in.delivered ? sat_inc(deliv_reg) : deliv_reg;
        fail_inc  = tok_in.delivered ? '0 : sat_inc(fail_reg);
        lhs       = {1'b0, deliv_inc, 8'h00};
        rhs       = 25'(cfg.ratio_target) * 25'(sent_inc);
        over      = sent_inc > CNT_W'(cfg.min_messages);
        bad       = (fail_inc >= CNT_W'(cfg.fail_limit)) || (over && (lhs < rhs));
        good      = over && (lhs > rhs);
        timer_dec = (timer_reg != '0) ? timer_reg - 1'b1 : timer_reg;
    end

    // Token pass-through with hit and free-slot collection for queries.
    always_comb
    begin
        tok_out = tok_in;
        if (tok_in.valid && (tok_in.op == OP_QUERY))
        begin
            if (match)
            begin
                tok_out.hit   = 1'b1;
                tok_out.power = trial_reg ? trial_p_reg : stable_reg;
            end
            if (!used_reg && !tok_in.free_found)
            begin
                tok_out.free_found = 1'b1;
                tok_out.free_idx   = cell_idx;
            end
        end
    end

    // Link state update.
    always_comb
    begin
        used_next    = used_reg;
        addr_next    = addr_reg;
        stable_next  = stable_reg;
        trial_p_next = trial_p_reg;
        sent_next    = sent_reg;
        deliv_next   = deliv_reg;
        fail_next    = fail_reg;
        trial_next   = trial_reg;
        timer_next   = timer_reg;
        if (alloc.en && (alloc.idx == cell_idx))
        begin
            used_next    = 1'b1;
            addr_next    = alloc.addr;
            stable_next  = alloc.power;
            trial_p_next = '0;
            sent_next    = '0;
            deliv_next   = '0;
            fail_next    = '0;
            trial_next   = 1'b0;
            timer_next   = '0;
        end
        else if (tok_in.valid)
        begin
            case (tok_in.op)
                OP_REPORT:
                begin
                    if (match)
                    begin
                        sent_next  = sent_inc;
                        deliv_next = deliv_inc;
                        fail_next  = fail_inc;
                        if (bad)
                        begin
                            if (!trial_reg)
                                stable_next = raise_power(stable_reg, cfg.power_step,
                                                          cfg.max_power);
                            timer_next = cfg.interval_ticks;
                            sent_next  = '0;
                            deliv_next = '0;
                            fail_next  = '0;
                            trial_next = 1'b0;
                        end
                        else if (trial_reg && good)
                        begin
                            stable_next  = trial_p_reg;
                            sent_next    = '0;
                            deliv_next   = '0;
                            fail_next    = '0;
                            trial_p_next = lower_power(trial_p_reg, cfg.power_step);
                        end
                    end
                end
                OP_TICK:
                begin
                    if (used_reg)
                    begin
                        timer_next = timer_dec;
                        if (timer_dec == '0)
                        begin
                            if (!trial_reg)
                            begin
                                sent_next    = '0;
                                deliv_next   = '0;
                                fail_next    = '0;
                                trial_next   = 1'b1;
                                trial_p_next = lower_power(stable_reg, cfg.power_step);
                            end
                            timer_next = cfg.interval_ticks;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= 1'b0;
        else
            used_reg <= used_next;
    end

    // Link payload.
    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        stable_reg  <= stable_next;
        trial_p_reg <= trial_p_next;
        sent_reg    <= sent_next;
        deliv_reg   <= deliv_next;
        fail_reg    <= fail_next;
        trial_reg   <= trial_next;
        timer_reg   <= timer_next;
    end

endmodule

/* design/per_link_adaptive_tx_power.sv */
// Path: an accepted transaction enters token register 0 and passes each link
// cell into the next token register, up to token register ENTRIES; a query
// waits there while an unread result is held, then writes the result register.
// One transaction at a time: a new one is accepted only once the last has left.
// Reset: all links are free and configuration takes its default values; there
// is no clearing pass.
// ----------------------------------------------------------------------------
// Per-link adaptive transmit power
// Neighbor link table built as a chain of link cells that a token walks.
// ----------------------------------------------------------------------------
module per_link_adaptive_tx_power
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [aptp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aptp_pkg::CFG_W-1:0]     cfg_data,
    aptp_in_if.sink                        in_ch,
    aptp_out_if.source                     out_ch
);
    import aptp_pkg::*;

    cfg_t   cfg_reg;
    tok_t   tok_reg [ENTRIES+1];
    tok_t   tok_out [ENTRIES];
    tok_t   tok_new, done_next;
    alloc_t alloc;
    logic   busy_reg, busy_next;
    logic   consume, is_query;
    logic   out_valid_reg, out_valid_next;
    logic signed [7:0] out_power_reg;
    logic   out_pv_reg, out_full_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_power      <= 8'sd0;
            cfg_reg.power_step     <= 7'd3;
            cfg_reg.fail_limit     <= 8'd3;
            cfg_reg.min_messages   <= 10'd10;
            cfg_reg.ratio_target   <= 9'd230;
            cfg_reg.interval_ticks <= 16'd60;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_POWER:  cfg_reg.max_power      <= cfg_data[7:0];
                CFG_POWER_STEP: cfg_reg.power_step     <= cfg_data[6:0];
                CFG_FAIL_LIMIT: cfg_reg.fail_limit     <= cfg_data[7:0];
                CFG_MIN_MSGS:   cfg_reg.min_messages   <= cfg_data[9:0];
                CFG_RATIO:      cfg_reg.ratio_target   <= cfg_data[8:0];
                CFG_INTERVAL:   cfg_reg.interval_ticks <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Incoming transaction becomes a token.
    assign in_ch.ready = !busy_reg;

    always_comb
    begin
        tok_new            = '0;
        tok_new.valid      = in_ch.valid && !busy_reg;
        tok_new.op         = op_t'(in_ch.opcode);
        tok_new.addr       = in_ch.dest_addr;
        tok_new.delivered  = in_ch.delivered;
        tok_new.hop        = in_ch.is_next_hop;
    end

    // Cell chain.
    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_cell
        aptp_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg      (cfg_reg),
            .cell_idx (IDX_W'(k)),
            .alloc    (alloc),
            .tok_in   (tok_reg[k]),
            .tok_out  (tok_out[k])
        );
    end

    // Finished token leaves when its result, if any, has room.
    assign is_query = tok_reg[ENTRIES].op == OP_QUERY;
    assign consume  = tok_reg[ENTRIES].valid &&
                      (!is_query || !out_valid_reg || out_ch.ready);

    always_comb
    begin
        alloc.en    = consume && is_query && !tok_reg[ENTRIES].hit &&
                      tok_reg[ENTRIES].hop && tok_reg[ENTRIES].free_found;
        alloc.idx   = tok_reg[ENTRIES].free_idx;
        alloc.addr  = tok_reg[ENTRIES].addr;
        alloc.power = cfg_reg.max_power;
    end

    always_comb
    begin
        done_next = tok_reg[ENTRIES];
        if (tok_out[ENTRIES-1].valid)
            done_next = tok_out[ENTRIES-1];
        else if (consume)
            done_next.valid = 1'b0;
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (tok_new.valid)
            busy_next = 1'b1;
        else if (consume)
            busy_next = 1'b0;
    end

    // Token stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ENTRIES; k++)
                tok_reg[k] <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            tok_reg[0] <= tok_new;
            for (int k = 1; k < ENTRIES; k++)
                tok_reg[k] <= tok_out[k-1];
            tok_reg[ENTRIES] <= done_next;
            busy_reg <= busy_next;
        end
    end

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (consume && is_query)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (consume && is_query)
        begin
            out_power_reg <= tok_reg[ENTRIES].hit ? tok_reg[ENTRIES].power : 8'sd0;
            out_pv_reg    <= tok_reg[ENTRIES].hit;
            out_full_reg  <= !tok_reg[ENTRIES].hit && tok_reg[ENTRIES].hop &&
                             !tok_reg[ENTRIES].free_found;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.tx_power    = out_power_reg;
    assign out_ch.power_valid = out_pv_reg;
    assign out_ch.table_full  = out_full_reg;

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Adaptive transmit power testbench
// Drives report, query, tick and no-op transactions into the link table, predicts
// each query result with a behavioral copy of the table, and checks results
// in order under random idling on both channels and several configurations.
// ----------------------------------------------------------------------------
module tb_top;
    import aptp_pkg::*;

    localparam int NLINK    = 8;
    localparam int SETTLE   = 40;
    localparam int MAX_ERRS = 10;

    // Expected query result.
    typedef struct packed {
        logic signed [7:0] tx_power;
        logic              power_valid;
        logic              table_full;
    } power_res_t;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [2:0]      cfg_index;
    logic [15:0]     cfg_data;

    aptp_in_if  in_ch ();
    aptp_out_if out_ch ();

    per_link_adaptive_tx_power dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // Predicted configuration.
    int m_max_power;
    int m_step;
    int m_fail_limit;
    int m_min_msgs;
    int m_ratio;
    int m_interval;

    // Predicted link table.
    bit          l_used    [NLINK];
    bit [15:0]   l_addr    [NLINK];
    int          l_stable  [NLINK];
    int          l_trial   [NLINK];
    int          l_sent    [NLINK];
    int          l_deliv   [NLINK];
    int          l_fails   [NLINK];
    bit          l_in_trial[NLINK];
    int          l_timer   [NLINK];

    power_res_t  pending_powers[$];
    int          mismatches;
    int          results_seen;
    int          items_sent;
    bit          quiet;

    // Known addresses for well-formed traffic.
    bit [15:0]   pool[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("timeout with %0d results pending", pending_powers.size());
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic int clamp8(input int p);
        if (p > 127)
            return 127;
        if (p < -128)
            return -128;
        return p;
    endfunction

    function automatic int count_up(input int c);
        return (c >= 65535) ? 65535 : c + 1;
    endfunction

    function automatic int find_link(input bit [15:0] a);
        for (int i = 0; i < NLINK; i++)
            if (l_used[i] && l_addr[i] == a)
                return i;
        return -1;
    endfunction

    // Update one link after a transmit report.
    function automatic void apply_report(input int i, input bit ok);
        longint lhs;
        longint rhs;
        bit     bad;
        int     p;
        l_sent[i] = count_up(l_sent[i]);
        if (ok)
        begin
            l_deliv[i] = count_up(l_deliv[i]);
            l_fails[i] = 0;
        end
        else
            l_fails[i] = count_up(l_fails[i]);
        lhs = longint'(l_deliv[i]) * 256;
        rhs = longint'(m_ratio) * l_sent[i];
        bad = (l_fails[i] >= m_fail_limit) || (l_sent[i] > m_min_msgs && lhs < rhs);
        if (bad)
        begin
            if (!l_in_trial[i])
            begin
                p = l_stable[i] + m_step;
                if (p > m_max_power)
                    p = m_max_power;
                l_stable[i] = clamp8(p);
            end
            l_timer[i] = m_interval;
            l_sent[i] = 0;
            l_deliv[i] = 0;
            l_fails[i] = 0;
            l_in_trial[i] = 0;
        end
        if (l_in_trial[i] && l_sent[i] > m_min_msgs && lhs > rhs)
        begin
            l_stable[i] = l_trial[i];
            l_sent[i] = 0;
            l_deliv[i] = 0;
            l_fails[i] = 0;
            l_trial[i] = clamp8(l_trial[i] - m_step);
        end
    endfunction

    // Run every used link's timer by one tick.
    function automatic void apply_tick();
        for (int i = 0; i < NLINK; i++)
        begin
            if (!l_used[i])
                continue;
            if (l_timer[i] != 0)
                l_timer[i]--;
            if (l_timer[i] != 0)
                continue;
            if (!l_in_trial[i])
            begin
                l_sent[i] = 0;
                l_deliv[i] = 0;
                l_fails[i] = 0;
                l_in_trial[i] = 1;
                l_trial[i] = clamp8(l_stable[i] - m_step);
            end
            l_timer[i] = m_interval;
        end
    endfunction

    // Predict the table for one accepted transaction.
    function automatic void predict_event(input op_t op, input bit [15:0] a,
                                          input bit ok, input bit hop);
        power_res_t r;
        int         i;
        r = '0;
        case (op)
            OP_REPORT:
            begin
                i = find_link(a);
                if (i >= 0)
                    apply_report(i, ok);
            end
            OP_TICK:
                apply_tick();
            OP_QUERY:
            begin
                i = find_link(a);
                if (i >= 0)
                begin
                    r.tx_power = 8'(l_in_trial[i] ? l_trial[i] : l_stable[i]);
                    r.power_valid = 1'b1;
                end
                else if (hop)
                begin
                    i = 0;
                    while (i < NLINK && l_used[i])
                        i++;
                    if (i >= NLINK)
                        r.table_full = 1'b1;
                    else
                    begin
                        l_used[i] = 1;
                        l_addr[i] = a;
                        l_stable[i] = m_max_power;
                        l_trial[i] = 0;
                        l_sent[i] = 0;
                        l_deliv[i] = 0;
                        l_fails[i] = 0;
                        l_in_trial[i] = 0;
                        l_timer[i] = 0;
                    end
                end
                pending_powers.push_back(r);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Send one transaction and predict its effect.
    task automatic send_event(input op_t op, input bit [15:0] a,
                              input bit ok, input bit hop);
        // Step past the falling edge where the previous transaction was dropped.
        @(negedge clk);
        if (!quiet)
            while ($urandom_range(99) < 13)
                @(negedge clk);
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.dest_addr   <= a;
        in_ch.delivered   <= ok;
        in_ch.is_next_hop <= hop;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_event(op, a, ok, hop);
        items_sent++;
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    // Write one register once the block has drained.
    task automatic write_reg(input cfg_idx_t idx, input int v);
        while (pending_powers.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 16'(v);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_POWER:  m_max_power  = int'($signed(8'(v)));
            CFG_POWER_STEP: m_step       = v & 8'h7f;
            CFG_FAIL_LIMIT: m_fail_limit = v & 8'hff;
            CFG_MIN_MSGS:   m_min_msgs   = v & 10'h3ff;
            CFG_RATIO:      m_ratio      = v & 9'h1ff;
            default:        m_interval   = v & 16'hffff;
        endcase
    endtask

    task automatic set_all(input int mp, input int st, input int fl, input int mm,
                           input int rt, input int iv);
        write_reg(CFG_MAX_POWER, mp);
        write_reg(CFG_POWER_STEP, st);
        write_reg(CFG_FAIL_LIMIT, fl);
        write_reg(CFG_MIN_MSGS, mm);
        write_reg(CFG_RATIO, rt);
        write_reg(CFG_INTERVAL, iv);
    endtask

    // Check each result transaction against the oldest expectation.
    initial
    begin
        power_res_t want;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 13);
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (pending_powers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_ERRS)
                        $display("unexpected result power %0d", out_ch.tx_power);
                end
                else
                begin
                    want = pending_powers.pop_front();
                    if (out_ch.tx_power !== want.tx_power
                        || out_ch.power_valid !== want.power_valid
                        || out_ch.table_full !== want.table_full)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_ERRS)
                            $display("result %0d: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     results_seen, want.tx_power, want.power_valid,
                                     want.table_full, out_ch.tx_power,
                                     out_ch.power_valid, out_ch.table_full);
                    end
                end
            end
        end
    end

    // Fill the table, overflow it, and exercise every opcode and field extreme.
    task automatic test_directed();
        send_event(OP_QUERY, 16'h0000, 0, 0);
        send_event(OP_REPORT, 16'hffff, 1, 0);
        for (int i = 0; i < NLINK; i++)
            send_event(OP_QUERY, (i == 7) ? 16'hffff : 16'(i * 16'h2493), 0, 1);
        send_event(OP_QUERY, 16'h5a5a, 0, 1);
        send_event(OP_QUERY, 16'hffff, 1, 1);
        send_event(OP_TICK, 16'h0, 0, 0);
        send_event(OP_QUERY, 16'h0000, 0, 0);
        send_event(OP_REPORT, 16'h0000, 0, 1);
        send_event(OP_REPORT, 16'h0000, 0, 0);
        send_event(OP_REPORT, 16'h0000, 0, 0);
        send_event(OP_QUERY, 16'h0000, 0, 0);
        send_event(OP_NONE, 16'hffff, 1, 1);
        send_event(OP_QUERY, 16'h2493, 1, 0);
    endtask

    // Mostly well-formed traffic on a small address pool.
    task automatic test_random(input int n);
        int          r;
        bit [15:0]   a;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            a = (pool.size() != 0 && $urandom_range(9) != 0)
                ? pool[$urandom_range(pool.size() - 1)] : 16'($urandom);
            if (r < 60)
                send_event(OP_REPORT, a, $urandom_range(99) < 80, $urandom_range(1));
            else if (r < 80)
                send_event(OP_QUERY, a, $urandom_range(1), $urandom_range(9) != 0);
            else if (r < 98)
                send_event(OP_TICK, 16'($urandom), $urandom_range(1), $urandom_range(1));
            else
                send_event(OP_NONE, a, $urandom_range(1), $urandom_range(1));
        end
    endtask

    // Random traffic under several configurations, extremes included.
    task automatic test_settings();
        for (int i = 0; i < 10; i++)
            pool.push_back(16'($urandom));
        set_all(127, 127, 255, 1023, 256, 65535);
        test_random(150);
        set_all(-128, 0, 1, 0, 0, 1);
        test_random(150);
        set_all(20, 5, 0, 4, 200, 3);
        test_random(200);
        set_all(-5, 40, 2, 6, 230, 8);
        test_random(300);
        quiet = 1;
        test_random(250);
        quiet = 0;
        set_all(100, 3, 3, 10, 230, 60);
        test_random(450);
        set_all(0, 1, 4, 2, 128, 5);
        test_random(330);
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_NONE;
        in_ch.dest_addr = '0;
        in_ch.delivered = 1'b0;
        in_ch.is_next_hop = 1'b0;
        quiet = 0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        m_max_power = 0;
        m_step = 3;
        m_fail_limit = 3;
        m_min_msgs = 10;
        m_ratio = 230;
        m_interval = 60;
        for (int i = 0; i < NLINK; i++)
            l_used[i] = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_settings();

        waited = 0;
        while (pending_powers.size() != 0 && waited < 100000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE) @(negedge clk);
        $display("%0d transactions sent, %0d query results checked, %0d mismatches",
                 items_sent, results_seen, mismatches);
        if (mismatches == 0 && pending_powers.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
